>>> design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on the same clock edge, off while reset is held.
`define ASGLU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Concurrent implication checked on the next clock edge, off while reset is held.
`define ASGLU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/asglu_pkg.sv
// Package with the types, constants and register codes of the audio gain/lowpass/mu-law block.
`default_nettype none

package asglu_pkg;

  // Payload and configuration widths.
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PCT_W      = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned FMT_W      = 2;

  // Gain product: magnitude times percent.
  localparam int unsigned PROD_W = SAMPLE_W + PCT_W;

  // Exact division by 100 through a reciprocal: q = (p * DIV100_MULT) >> DIV100_SHIFT.
  // The rounding error stays below one part in 100 for every p below 2^24 / 1.2.
  localparam int unsigned DIV100_SHIFT = 30;
  localparam int unsigned DIV100_W     = 24;
  localparam logic [DIV100_W-1:0] DIV100_MULT =
    DIV100_W'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);
  localparam int unsigned QUOT_W = 17;

  // Lowpass accumulator: x + 8*prev - prev needs four extra bits.
  localparam int unsigned ACC_W = SAMPLE_W + 4;

  // Mu-law encoder constants.
  localparam int unsigned MAG_W = 15;
  localparam logic [MAG_W-1:0] MU_BIAS = MAG_W'(132);
  localparam logic [MAG_W-1:0] MU_CLIP = MAG_W'(32635);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_EN   = 2'd0,
    CFG_GAIN_PCT  = 2'd1,
    CFG_FILT_MODE = 2'd2,
    CFG_OUT_FMT   = 2'd3
  } cfg_idx_e;

  // Output formats; the unused code acts like raw.
  typedef enum logic [FMT_W-1:0] {
    FMT_RAW   = 2'd0,
    FMT_SWAP  = 2'd1,
    FMT_MULAW = 2'd2
  } out_fmt_e;

endpackage

`default_nettype wire

>>> design/asglu_if.sv
// Stream interfaces for the sample input and the output word channel.
`default_nettype none

interface asglu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [asglu_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface asglu_out_if;
  logic                           valid;
  logic                           ready;
  logic [asglu_pkg::SAMPLE_W-1:0] out_word;

  modport source (output valid, output out_word, input ready);
  modport sink   (input valid, input out_word, output ready);
endinterface

`default_nettype wire

>>> design/asglu_mulaw.sv
// G.711 mu-law encoder: linear 16-bit sample to one code byte, combinational.
`default_nettype none

module asglu_mulaw (
  input  logic signed [asglu_pkg::SAMPLE_W-1:0] lin_i,
  output logic        [7:0]                     code_o
);

  logic                            sign;
  logic [asglu_pkg::SAMPLE_W:0]    mag;
  logic [asglu_pkg::MAG_W-1:0]     mag_clip;
  logic [asglu_pkg::MAG_W-1:0]     biased;
  logic [7:0]                      top;
  logic [2:0]                      expo;
  logic [3:0]                      mant;
  logic [asglu_pkg::MAG_W-1:0]     shifted;

  // Magnitude in 17 bits so that the most negative sample does not wrap.
  assign sign = lin_i[asglu_pkg::SAMPLE_W-1];
  assign mag  = sign ? ((asglu_pkg::SAMPLE_W+1)'(0) - {lin_i[asglu_pkg::SAMPLE_W-1], lin_i})
                     : {1'b0, lin_i};

  // Clip large magnitudes, then add the bias.
  assign mag_clip = (mag > {2'b00, asglu_pkg::MU_CLIP}) ? asglu_pkg::MU_CLIP
                                                        : mag[asglu_pkg::MAG_W-1:0];
  assign biased   = mag_clip + asglu_pkg::MU_BIAS;
  assign top      = biased[asglu_pkg::MAG_W-1:7];

  // Segment number is the position of the highest set bit of the top byte.
  always_comb begin
    expo = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (top[i]) begin
        expo = 3'(i);
      end
    end
  end

  // Four bits under the leading one form the step within the segment.
  assign shifted = biased >> ({2'b00, expo} + 5'd3);
  assign mant    = shifted[3:0];

  assign code_o = ~{sign, expo, mant};

endmodule

`default_nettype wire

>>> design/audio_sample_gain_lowpass_ulaw_top.sv
// Top level of the audio sample gain, lowpass and mu-law output block.
//
// Usage: one signed 16-bit sample enters per item on in_s (valid/ready), and one
// 16-bit word leaves per item on out_m (valid/ready), in the same order.
// The word is the raw sample, the byte-swapped sample, or a mu-law byte in the
// low eight bits, as selected by the output format register.
// Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) that the user
// must write only while no item is inside the block; the block does not enforce this.
// An item passes five registers: input register, percent product, reciprocal
// division by 100, gain and lowpass, formatting into the output register.
// Throughput: one item per cycle while out_m is not stalled, set by the five-stage
// pipeline in which each stage holds one item; the lowpass feedback register
// closes within one stage.
// Reset clears all valid bits, the configuration registers and the lowpass state.
// When the receiver stalls, the output word holds; the stages behind it keep
// filling their empty slots and in_s.ready drops only once all five are full.
`default_nettype none

module audio_sample_gain_lowpass_ulaw_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  asglu_in_if.sink                                in_s,
  asglu_out_if.source                             out_m,
  input  logic                                    cfg_we_i,
  input  logic [asglu_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [asglu_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  // Configuration registers.
  logic                           gain_en_q;
  logic [asglu_pkg::PCT_W-1:0]    gain_pct_q;
  logic                           filt_mode_q;
  logic [asglu_pkg::FMT_W-1:0]    out_fmt_q;

  // Pipeline valid bits and load enables.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic ld1, ld2, ld3, ld4, ld5;

  // Stage payloads.
  logic signed [asglu_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic signed [asglu_pkg::SAMPLE_W-1:0] s2_sample_q;
  logic        [asglu_pkg::PROD_W-1:0]   s2_prod_q;
  logic signed [asglu_pkg::SAMPLE_W-1:0] s3_sample_q;
  logic        [asglu_pkg::QUOT_W-1:0]   s3_quot_q;
  logic signed [asglu_pkg::SAMPLE_W-1:0] s4_val_q;
  logic        [asglu_pkg::SAMPLE_W-1:0] out_word_q;

  // Lowpass state.
  logic signed [asglu_pkg::SAMPLE_W-1:0] lp_prev_q;

  // Combinational datapath signals.
  logic        [asglu_pkg::SAMPLE_W-1:0]                     s1_mag;
  logic        [asglu_pkg::PROD_W-1:0]                       s1_prod;
  logic        [asglu_pkg::PROD_W+asglu_pkg::DIV100_W-1:0]   s2_recip;
  logic        [asglu_pkg::SAMPLE_W-1:0]                     s3_term;
  logic signed [asglu_pkg::SAMPLE_W-1:0]                     s3_gained;
  logic signed [asglu_pkg::ACC_W-1:0]                        s3_acc;
  logic signed [asglu_pkg::ACC_W-1:0]                        s3_acc_sh;
  logic signed [asglu_pkg::SAMPLE_W-1:0]                     s3_lp;
  logic signed [asglu_pkg::SAMPLE_W-1:0]                     s3_val;
  logic        [7:0]                                         s4_mulaw;
  logic        [asglu_pkg::SAMPLE_W-1:0]                     s4_word;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_en_q   <= 1'b0;
      gain_pct_q  <= '0;
      filt_mode_q <= 1'b0;
      out_fmt_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        asglu_pkg::CFG_GAIN_EN:   gain_en_q   <= cfg_data_i[0];
        asglu_pkg::CFG_GAIN_PCT:  gain_pct_q  <= cfg_data_i[asglu_pkg::PCT_W-1:0];
        asglu_pkg::CFG_FILT_MODE: filt_mode_q <= cfg_data_i[0];
        asglu_pkg::CFG_OUT_FMT:   out_fmt_q   <= cfg_data_i[asglu_pkg::FMT_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  assign ld5 = !s5_v_q || out_m.ready;
  assign ld4 = !s4_v_q || ld5;
  assign ld3 = !s3_v_q || ld4;
  assign ld2 = !s2_v_q || ld3;
  assign ld1 = !s1_v_q || ld2;

  assign in_s.ready     = ld1;
  assign out_m.valid    = s5_v_q;
  assign out_m.out_word = out_word_q;

  // Valid bits follow the items down the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (ld1) s1_v_q <= in_s.valid;
      if (ld2) s2_v_q <= s1_v_q;
      if (ld3) s3_v_q <= s2_v_q;
      if (ld4) s4_v_q <= s3_v_q;
      if (ld5) s5_v_q <= s4_v_q;
    end
  end

  // Stage 1: magnitude of the sample times the gain percent.
  assign s1_mag  = s1_sample_q[asglu_pkg::SAMPLE_W-1] ? (asglu_pkg::SAMPLE_W'(0) - s1_sample_q)
                                                       : s1_sample_q;
  assign s1_prod = asglu_pkg::PROD_W'(s1_mag) * asglu_pkg::PROD_W'(gain_pct_q);

  // Stage 2: division by 100 as a multiplication by the reciprocal.
  assign s2_recip = (asglu_pkg::PROD_W+asglu_pkg::DIV100_W)'(s2_prod_q)
                  * (asglu_pkg::PROD_W+asglu_pkg::DIV100_W)'(asglu_pkg::DIV100_MULT);

  // Stage 3: signed gain term added with 16-bit wrap, then the optional lowpass.
  assign s3_term   = s3_sample_q[asglu_pkg::SAMPLE_W-1]
                   ? (asglu_pkg::SAMPLE_W'(0) - s3_quot_q[asglu_pkg::SAMPLE_W-1:0])
                   : s3_quot_q[asglu_pkg::SAMPLE_W-1:0];
  assign s3_gained = gain_en_q ? (s3_sample_q + $signed(s3_term)) : s3_sample_q;
  assign s3_acc    = asglu_pkg::ACC_W'(s3_gained)
                   + (asglu_pkg::ACC_W'(lp_prev_q) <<< 3)
                   - asglu_pkg::ACC_W'(lp_prev_q);
  assign s3_acc_sh = s3_acc >>> 3;
  assign s3_lp     = s3_acc_sh[asglu_pkg::SAMPLE_W-1:0];
  assign s3_val    = filt_mode_q ? s3_lp : s3_gained;

  // Stage 4: output formatting.
  asglu_mulaw u_mulaw (
    .lin_i  (s4_val_q),
    .code_o (s4_mulaw)
  );

  always_comb begin
    case (out_fmt_q)
      asglu_pkg::FMT_SWAP:  s4_word = {s4_val_q[7:0], s4_val_q[15:8]};
      asglu_pkg::FMT_MULAW: s4_word = {8'h00, s4_mulaw};
      default:              s4_word = s4_val_q;
    endcase
  end

  // Payload registers load with their stage.
  always_ff @(posedge clk_i) begin
    if (ld1) s1_sample_q <= in_s.sample;
    if (ld2) begin
      s2_sample_q <= s1_sample_q;
      s2_prod_q   <= s1_prod;
    end
    if (ld3) begin
      s3_sample_q <= s2_sample_q;
      s3_quot_q   <= s2_recip[asglu_pkg::DIV100_SHIFT +: asglu_pkg::QUOT_W];
    end
    if (ld4) s4_val_q   <= s3_val;
    if (ld5) out_word_q <= s4_word;
  end

  // Lowpass state advances with each filtered item leaving stage 3.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_prev_q <= '0;
    end else if (ld4 && s3_v_q && filt_mode_q) begin
      lp_prev_q <= s3_lp;
    end
  end

endmodule

`default_nettype wire

>>> design/asglu_checker.sv
// Port-level checker for the audio gain/lowpass/mu-law block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module asglu_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic [asglu_pkg::SAMPLE_W-1:0]       out_word_i,
  input logic                                 cfg_we_i,
  input logic [asglu_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [asglu_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [asglu_pkg::FMT_W-1:0] fmt_q;
  logic                        mulaw_sel;

  // Shadow of the output format register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == asglu_pkg::CFG_OUT_FMT)) begin
      fmt_q <= cfg_data_i[asglu_pkg::FMT_W-1:0];
    end
  end

  assign mulaw_sel = (fmt_q == asglu_pkg::FMT_MULAW);

  // A stalled item stays offered.
  `ASGLU_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "output item dropped while stalled")

  // A stalled word does not change.
  `ASGLU_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_word_i), "output word changed while stalled")

  // Input back-pressure only comes from a stalled, full output.
  `ASGLU_ASSERT_IMP(a_ready_cause, !in_ready_i, out_valid_i && !out_ready_i, "input stalled without output stall")

  // Mu-law words carry a zero upper byte.
  `ASGLU_ASSERT_IMP(a_mulaw_byte, out_valid_i && mulaw_sel, out_word_i[15:8] == 8'h00, "mu-law word has a nonzero upper byte")

  // With no item offered and no word waiting, the first stage is free in the next cycle.
  `ASGLU_ASSERT_NXT(a_idle_ready, !in_valid_i && !out_valid_i, in_ready_i, "block not ready while empty")

endmodule

bind audio_sample_gain_lowpass_ulaw_top asglu_checker u_asglu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_m.valid),
  .out_ready_i (out_m.ready),
  .out_word_i  (out_m.out_word),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i)
);

`default_nettype wire
